@@ rtl/fdc_pkg.sv @@
// ----------------------------------------------------------------------------
// fdc_pkg: shared types, constants and CRC functions
// Frame layout positions, status codes, result record and the parallel
// CRC-32/MPEG-2 word update used by the frame decoder.
// ----------------------------------------------------------------------------
package fdc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Byte positions within a 14-byte frame.
    typedef logic [3:0] pos_t;
    localparam pos_t POS_HEADER = 4'd0;
    localparam pos_t POS_FW1_B0 = 4'd1;
    localparam pos_t POS_FW1_B1 = 4'd2;
    localparam pos_t POS_FW2_B0 = 4'd3;
    localparam pos_t POS_FW2_B1 = 4'd4;
    localparam pos_t POS_FW2_B2 = 4'd5;
    localparam pos_t POS_PL_B0  = 4'd6;
    localparam pos_t POS_PL_B1  = 4'd7;
    localparam pos_t POS_PL_B2  = 4'd8;
    localparam pos_t POS_PL_B3  = 4'd9;
    localparam pos_t POS_CRC_B0 = 4'd10;
    localparam pos_t POS_CRC_B1 = 4'd11;
    localparam pos_t POS_CRC_B2 = 4'd12;
    localparam pos_t POS_CRC_B3 = 4'd13;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_CRC_ERR = 2'd1;
    localparam status_t STATUS_HDR_ERR = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rx_item_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  destination;
        logic [1:0]  priority_res;
        logic [3:0]  action;
        logic [4:0]  source;
        logic [5:0]  device_kind;
        logic [5:0]  device_number;
        logic [3:0]  data_kind;
        logic [7:0]  operation_code;
        logic [31:0] payload;
    } result_t;

    typedef logic [31:0][31:0] crc_mask_t;

    // Thirty-two serial shifts of the register; only used to build the
    // constant matrix below at elaboration.
    function automatic logic [31:0] crc_shift32(input logic [31:0] v);
        logic [31:0] c;
        c = v;
        for (int k = 0; k < 32; k++)
        begin
            c = {c[30:0], 1'b0} ^ (c[31] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    // Row i holds the input bits whose parity gives result bit i.
    function automatic crc_mask_t crc_build_masks();
        crc_mask_t   m;
        logic [31:0] col;
        m = '0;
        for (int j = 0; j < 32; j++)
        begin
            col = crc_shift32(32'h1 << j);
            for (int i = 0; i < 32; i++)
            begin
                m[i][j] = col[i];
            end
        end
        return m;
    endfunction

    localparam crc_mask_t CRC_MASK = crc_build_masks();

    // One 32-bit word fed MSB first, as a flat XOR network.
    function automatic logic [31:0] crc_word(input logic [31:0] crc,
                                             input logic [31:0] word);
        logic [31:0] x;
        logic [31:0] r;
        x = crc ^ word;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = ^(x & CRC_MASK[i]);
        end
        return r;
    endfunction

endpackage

@@ rtl/fdc_channels.sv @@
// ----------------------------------------------------------------------------
// fdc_channels: handshake channels of the frame decoder
// Received byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface fdc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface fdc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  destination;
    logic [1:0]  priority_res;
    logic [3:0]  action;
    logic [4:0]  source_addr;
    logic [5:0]  device_kind;
    logic [5:0]  device_number;
    logic [3:0]  data_kind;
    logic [7:0]  operation_code;
    logic [31:0] payload;

    modport source (output valid, input ready, output status, output destination,
                    output priority_res, output action, output source_addr,
                    output device_kind, output device_number, output data_kind,
                    output operation_code, output payload);
    modport sink   (input valid, output ready, input status, input destination,
                    input priority_res, input action, input source_addr,
                    input device_kind, input device_number, input data_kind,
                    input operation_code, input payload);
endinterface

interface fdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fdc_in_stage.sv @@
// ----------------------------------------------------------------------------
// fdc_in_stage: input register
// Holds one received byte and its frame start flag until the frame core
// takes it; a new byte is taken in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module fdc_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    fdc_rx_if.sink            rx,
    input  logic              s1_take,
    output logic              s1_valid,
    output fdc_pkg::rx_item_t s1_item
);

    logic              valid_reg;
    fdc_pkg::rx_item_t item_reg;

    assign rx.ready = !valid_reg || s1_take;
    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (s1_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            item_reg.rx_byte     <= rx.rx_byte;
            item_reg.frame_start <= rx.frame_start;
        end
    end

endmodule

@@ rtl/fdc_frame_core.sv @@
// ----------------------------------------------------------------------------
// fdc_frame_core: frame assembly, CRC update and result register
// Tracks the byte position, gathers the header, field words, payload and
// received CRC, runs the word-wide CRC and registers the frame result.
// ----------------------------------------------------------------------------
module fdc_frame_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  fdc_pkg::rx_item_t s1_item,
    input  logic [7:0]        expected_header,
    output logic              s1_take,
    fdc_res_if.source         res
);

    fdc_pkg::pos_t    count_reg, count_next;
    logic [31:0]      crc_reg, crc_next;
    logic [7:0]       header_reg, header_next;
    logic [15:0]      fw1_reg, fw1_next;
    logic [23:0]      fw2_reg, fw2_next;
    logic [31:0]      payload_reg, payload_next;
    logic [23:0]      rxcrc_reg, rxcrc_next;
    logic             res_valid_reg;
    fdc_pkg::result_t res_reg, res_next;

    fdc_pkg::pos_t    pos;
    logic [7:0]       b;
    logic             is_last;
    logic [31:0]      rx_crc;

    assign b = s1_item.rx_byte;

    always_comb
    begin
        if (s1_item.frame_start || (count_reg > fdc_pkg::POS_CRC_B3))
        begin
            pos = fdc_pkg::POS_HEADER;
        end
        else
        begin
            pos = count_reg;
        end
    end

    assign is_last = (pos == fdc_pkg::POS_CRC_B3);
    // The last byte of a frame needs room in the result register.
    assign s1_take = s1_valid && (!is_last || !res_valid_reg || res.ready);

    always_comb
    begin
        crc_next     = crc_reg;
        header_next  = header_reg;
        fw1_next     = fw1_reg;
        fw2_next     = fw2_reg;
        payload_next = payload_reg;
        rxcrc_next   = rxcrc_reg;
        unique case (pos)
            fdc_pkg::POS_HEADER:
            begin
                crc_next    = fdc_pkg::CRC_INIT;
                header_next = b;
            end
            fdc_pkg::POS_FW1_B0: fw1_next[7:0]  = b;
            fdc_pkg::POS_FW1_B1: fw1_next[15:8] = b;
            fdc_pkg::POS_FW2_B0:
            begin
                fw2_next = {16'h0, b};
                crc_next = fdc_pkg::crc_word(crc_reg, {b, fw1_reg, header_reg});
            end
            fdc_pkg::POS_FW2_B1: fw2_next[15:8]  = b;
            fdc_pkg::POS_FW2_B2: fw2_next[23:16] = b;
            fdc_pkg::POS_PL_B0:  payload_next    = {24'h0, b};
            fdc_pkg::POS_PL_B1:
            begin
                payload_next[15:8] = b;
                crc_next = fdc_pkg::crc_word(crc_reg,
                                             {b, payload_reg[7:0], fw2_reg[23:8]});
            end
            fdc_pkg::POS_PL_B2:  payload_next[23:16] = b;
            fdc_pkg::POS_PL_B3:
            begin
                payload_next[31:24] = b;
                // The last body word carries two bytes with its top half zero.
                crc_next = fdc_pkg::crc_word(crc_reg, {16'h0, b, payload_reg[23:16]});
            end
            fdc_pkg::POS_CRC_B0: rxcrc_next        = {16'h0, b};
            fdc_pkg::POS_CRC_B1: rxcrc_next[15:8]  = b;
            fdc_pkg::POS_CRC_B2: rxcrc_next[23:16] = b;
            fdc_pkg::POS_CRC_B3: crc_next          = fdc_pkg::CRC_INIT;
            default:
            begin
            end
        endcase
    end

    assign count_next = is_last ? fdc_pkg::POS_HEADER : (pos + 4'd1);
    assign rx_crc     = {b, rxcrc_reg};

    always_comb
    begin
        res_next = '0;
        if (rx_crc != crc_reg)
        begin
            res_next.status = fdc_pkg::STATUS_CRC_ERR;
        end
        else if (header_reg != expected_header)
        begin
            res_next.status = fdc_pkg::STATUS_HDR_ERR;
        end
        else
        begin
            res_next.status         = fdc_pkg::STATUS_OK;
            res_next.destination    = fw1_reg[4:0];
            res_next.priority_res   = fw1_reg[6:5];
            res_next.action         = fw1_reg[10:7];
            res_next.source         = fw1_reg[15:11];
            res_next.device_kind    = fw2_reg[5:0];
            res_next.device_number  = fw2_reg[11:6];
            res_next.data_kind      = fw2_reg[15:12];
            res_next.operation_code = fw2_reg[23:16];
            res_next.payload        = payload_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= fdc_pkg::POS_HEADER;
            crc_reg       <= fdc_pkg::CRC_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
            end
            if (s1_take && is_last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            header_reg  <= header_next;
            fw1_reg     <= fw1_next;
            fw2_reg     <= fw2_next;
            payload_reg <= payload_next;
            rxcrc_reg   <= rxcrc_next;
        end
        if (s1_take && is_last)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.status         = res_reg.status;
    assign res.destination    = res_reg.destination;
    assign res.priority_res   = res_reg.priority_res;
    assign res.action         = res_reg.action;
    assign res.source_addr    = res_reg.source;
    assign res.device_kind    = res_reg.device_kind;
    assign res.device_number  = res_reg.device_number;
    assign res.data_kind      = res_reg.data_kind;
    assign res.operation_code = res_reg.operation_code;
    assign res.payload        = res_reg.payload;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fdc_pkg::POS_CRC_B3)
        else $error("byte position beyond the last frame byte");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_take && is_last) |=> (res_valid_reg && (count_reg == fdc_pkg::POS_HEADER)))
        else $error("last frame byte did not produce a result");

    a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status != fdc_pkg::STATUS_OK))
        |-> ((res_reg.payload == 32'h0) && (res_reg.destination == 5'h0)
             && (res_reg.operation_code == 8'h0)))
        else $error("error result carries non-zero fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((res_reg.status == fdc_pkg::STATUS_OK)
                           || (res_reg.status == fdc_pkg::STATUS_CRC_ERR)
                           || (res_reg.status == fdc_pkg::STATUS_HDR_ERR)))
        else $error("undefined status code in result");

endmodule

@@ rtl/frame_decoder_crc32_check_unit.sv @@
// A frame's result is registered when its byte 13 passes from the input register to the frame core.
// Throughput: one byte per cycle while no held result stalls, set by the word-wide CRC step between registers.
// A stalled result holds back only the last byte of the following frame.
// Reset (rst_n, asynchronous, active low) clears the byte position, the CRC,
// the valid flags and expected_header; no clearing pass is needed.
// ----------------------------------------------------------------------------
// frame_decoder_crc32_check_unit: frame receiver with CRC-32/MPEG-2 check
// Takes 14-byte frames one byte per transfer, checks CRC and header and
// returns a status for each frame, with the decoded fields when both checks pass.
// ----------------------------------------------------------------------------
module frame_decoder_crc32_check_unit
(
    input  logic      clk,
    input  logic      rst_n,
    fdc_rx_if.sink    rx,
    fdc_res_if.source res,
    fdc_cfg_if.sink   cfg
);

    logic              s1_valid;
    logic              s1_take;
    fdc_pkg::rx_item_t s1_item;
    logic [7:0]        expected_header_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_header_reg <= 8'h00;
        end
        else if (cfg.valid && cfg.ready)
        begin
            expected_header_reg <= cfg.data;
        end
    end

    fdc_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .s1_take  (s1_take),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    fdc_frame_core u_frame_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s1_valid        (s1_valid),
        .s1_item         (s1_item),
        .expected_header (expected_header_reg),
        .s1_take         (s1_take),
        .res             (res)
    );

endmodule

@@ bench/fdc_bench_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdc_bench_pkg: frame layout and CRC arithmetic for the frame decoder bench
// A serial CRC-32/MPEG-2 word update and the check value of a whole frame,
// shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package fdc_bench_pkg;

    import fdc_pkg::*;

    // Byte 0 of a frame sits in bits 7:0.
    typedef logic [13:0][7:0] frame_bytes_t;

    // One word fed MSB first, one bit per shift.
    function automatic logic [31:0] crc32_word_step(input logic [31:0] crc,
                                                    input logic [31:0] word);
        logic [31:0] c;
        int          k;
        c = crc ^ word;
        for (k = 0; k < 32; k++)
        begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    // The body is read as little-endian words, the last one padded with zeros.
    function automatic logic [31:0] frame_crc(input frame_bytes_t f);
        logic [31:0] c;
        c = CRC_INIT;
        c = crc32_word_step(c, {f[3], f[2], f[1], f[0]});
        c = crc32_word_step(c, {f[7], f[6], f[5], f[4]});
        c = crc32_word_step(c, {16'h0000, f[9], f[8]});
        return c;
    endfunction

endpackage

@@ bench/fdc_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdc_result_checker: decoded frame predictor and result comparison
// Follows every byte transfer into the decoder, works out the result that a
// complete frame must give and compares each result transfer with it.
// ----------------------------------------------------------------------------
module fdc_result_checker
    import fdc_pkg::*;
    import fdc_bench_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fdc_rx_if    rx,
    fdc_res_if   res,
    fdc_cfg_if   cfg,
    output int   failures,
    output int   pending
);

    logic [7:0]  want_header;
    pos_t        next_pos;
    logic [31:0] crc_acc;
    logic [23:0] word_acc;
    logic [7:0]  header_byte;
    logic [15:0] field_one;
    logic [23:0] field_two;
    logic [31:0] payload_acc;
    logic [23:0] crc_rx_acc;
    result_t     decoded_q [$];
    int          mismatches;

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic fs);
        pos_t        pos;
        result_t     r;
        logic [31:0] crc_rx;
        pos = fs ? POS_HEADER : next_pos;
        case (pos)
            POS_HEADER:
            begin
                crc_acc     = CRC_INIT;
                header_byte = b;
                word_acc    = {16'h0000, b};
            end
            POS_FW1_B0:
            begin
                field_one      = {8'h00, b};
                word_acc[15:8] = b;
            end
            POS_FW1_B1:
            begin
                field_one[15:8] = b;
                word_acc[23:16] = b;
            end
            POS_FW2_B0:
            begin
                field_two = {16'h0000, b};
                crc_acc   = crc32_word_step(crc_acc, {b, word_acc});
                word_acc  = '0;
            end
            POS_FW2_B1:
            begin
                field_two[15:8] = b;
                word_acc        = {16'h0000, b};
            end
            POS_FW2_B2:
            begin
                field_two[23:16] = b;
                word_acc[15:8]   = b;
            end
            POS_PL_B0:
            begin
                payload_acc     = {24'h000000, b};
                word_acc[23:16] = b;
            end
            POS_PL_B1:
            begin
                payload_acc[15:8] = b;
                crc_acc           = crc32_word_step(crc_acc, {b, word_acc});
                word_acc          = '0;
            end
            POS_PL_B2:
            begin
                payload_acc[23:16] = b;
                word_acc           = {16'h0000, b};
            end
            POS_PL_B3:
            begin
                payload_acc[31:24] = b;
                crc_acc = crc32_word_step(crc_acc, {16'h0000, b, word_acc[7:0]});
                word_acc = '0;
            end
            POS_CRC_B0: crc_rx_acc = {16'h0000, b};
            POS_CRC_B1: crc_rx_acc[15:8] = b;
            POS_CRC_B2: crc_rx_acc[23:16] = b;
            default:
            begin
            end
        endcase

        if (pos == POS_CRC_B3)
        begin
            crc_rx = {b, crc_rx_acc};
            r = '0;
            // The CRC takes precedence over the header; the header is judged
            // against the register as it stands now.
            if (crc_rx != crc_acc)
            begin
                r.status = STATUS_CRC_ERR;
            end
            else if (header_byte != want_header)
            begin
                r.status = STATUS_HDR_ERR;
            end
            else
            begin
                r.status         = STATUS_OK;
                r.destination    = field_one[4:0];
                r.priority_res   = field_one[6:5];
                r.action         = field_one[10:7];
                r.source         = field_one[15:11];
                r.device_kind    = field_two[5:0];
                r.device_number  = field_two[11:6];
                r.data_kind      = field_two[15:12];
                r.operation_code = field_two[23:16];
                r.payload        = payload_acc;
            end
            decoded_q.push_back(r);
            next_pos = POS_HEADER;
            crc_acc  = CRC_INIT;
            word_acc = '0;
        end
        else
        begin
            next_pos = pos + 4'd1;
        end
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got.status         = res.status;
        got.destination    = res.destination;
        got.priority_res   = res.priority_res;
        got.action         = res.action;
        got.source         = res.source_addr;
        got.device_kind    = res.device_kind;
        got.device_number  = res.device_number;
        got.data_kind      = res.data_kind;
        got.operation_code = res.operation_code;
        got.payload        = res.payload;
        if (decoded_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result transfer with no frame outstanding, status %0d", got.status);
            end
            return;
        end
        want = decoded_q.pop_front();
        if (got.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.destination !== want.destination)
            note_mismatch("destination", 32'(want.destination), 32'(got.destination));
        if (got.priority_res !== want.priority_res)
            note_mismatch("priority_res", 32'(want.priority_res), 32'(got.priority_res));
        if (got.action !== want.action)
            note_mismatch("action", 32'(want.action), 32'(got.action));
        if (got.source !== want.source)
            note_mismatch("source", 32'(want.source), 32'(got.source));
        if (got.device_kind !== want.device_kind)
            note_mismatch("device_kind", 32'(want.device_kind), 32'(got.device_kind));
        if (got.device_number !== want.device_number)
            note_mismatch("device_number", 32'(want.device_number),
                          32'(got.device_number));
        if (got.data_kind !== want.data_kind)
            note_mismatch("data_kind", 32'(want.data_kind), 32'(got.data_kind));
        if (got.operation_code !== want.operation_code)
            note_mismatch("operation_code", 32'(want.operation_code),
                          32'(got.operation_code));
        if (got.payload !== want.payload)
            note_mismatch("payload", want.payload, got.payload);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            want_header = '0;
            next_pos    = POS_HEADER;
            crc_acc     = CRC_INIT;
            word_acc    = '0;
            header_byte = '0;
            field_one   = '0;
            field_two   = '0;
            payload_acc = '0;
            crc_rx_acc  = '0;
            mismatches  = 0;
            decoded_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                want_header = cfg.data;
            if (rx.valid && rx.ready)
                take_byte(rx.rx_byte, rx.frame_start);
            if (res.valid && res.ready)
                check_result();
        end
        failures = mismatches;
        pending  = decoded_q.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: frame decoder with CRC-32/MPEG-2 check, top level of the bench
// Feeds whole, cut-short, split and corrupted frames and line noise with
// random gaps on both channels, changes the header register between phases
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

    import fdc_pkg::*;
    import fdc_bench_pkg::*;

    localparam int ITEM_TARGET    = 1330;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int LATENCY_CYCLES = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_STALL     = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   failures;
    int   pending;
    int   cycle_count = 0;
    int   bytes_sent  = 0;
    int   stall_req   = 0;
    bit   rx_calm     = 1'b0;
    bit   res_calm    = 1'b0;

    fdc_rx_if  rx_ch ();
    fdc_res_if res_ch ();
    fdc_cfg_if cfg_ch ();

    frame_decoder_crc32_check_unit i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    fdc_result_checker i_chk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_ch),
        .res      (res_ch),
        .cfg      (cfg_ch),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic frame_bytes_t make_frame(input logic [7:0] hdr,
                                                input logic [71:0] body,
                                                input bit corrupt);
        frame_bytes_t f;
        logic [31:0]  c;
        int           i;
        f[0] = hdr;
        for (i = 1; i <= 9; i++)
        begin
            f[i] = body[8*(i-1) +: 8];
        end
        c = frame_crc(f);
        f[10] = c[7:0];
        f[11] = c[15:8];
        f[12] = c[23:16];
        f[13] = c[31:24];
        // A single flipped bit in the check bytes always breaks the CRC.
        if (corrupt)
        begin
            i = 10 + int'($urandom_range(0, 3));
            f[i] = f[i] ^ (8'h01 << $urandom_range(0, 7));
        end
        return f;
    endfunction

    function automatic logic [71:0] random_body();
        return 72'({$urandom, $urandom, $urandom});
    endfunction

    // Valid stays high from one transfer to the next when there is no gap.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = draw_gap(rx_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_start <= fs;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_span(input frame_bytes_t f, input int first_at, input int last_at,
                             input logic fs_first);
        int i;
        for (i = first_at; i <= last_at; i++)
        begin
            send_byte(f[i], (i == first_at) ? fs_first : 1'b0);
        end
    endtask

    task automatic rx_pause();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
    endtask

    task automatic write_header(input logic [7:0] v);
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (LATENCY_CYCLES) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: a random hold-off before each transfer, or one long one
    // when asked, during which the decoder fills up and stalls its input.
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                res_calm = !res_calm;
            gap = draw_gap(res_calm);
            if (stall_req > 0)
            begin
                gap       = stall_req;
                stall_req = 0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        frame_bytes_t f;
        frame_bytes_t carry_frame;
        logic [7:0]   hdr;
        logic [7:0]   next_hdr;
        logic [7:0]   hdr_pick;
        logic         fs;
        bit           carry;
        bit           need_start;
        int           phase;
        int           frames;
        int           kind;
        int           carry_at;
        int           n;

        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = '0;
        rx_ch.frame_start = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: all-ones frame that passes, a frame begun without a start
        // flag right at the boundary and then restarted mid-way, and an
        // all-zero frame whose header is wrong.
        write_header(8'hFF);
        f = make_frame(8'hFF, {72{1'b1}}, 1'b0);
        send_span(f, 0, 13, 1'b1);
        f = make_frame(8'h00, '0, 1'b0);
        send_span(f, 0, 2, 1'b0);
        send_span(f, 0, 13, 1'b1);
        rx_pause();

        hdr        = 8'h00;
        phase      = 0;
        carry      = 1'b0;
        carry_at   = 0;
        need_start = 1'b0;
        while (bytes_sent < ITEM_TARGET)
        begin
            write_header(hdr);
            if (phase == 2)
                stall_req = LONG_STALL;
            // Finish a frame whose first bytes went in under the old header.
            if (carry)
            begin
                send_span(carry_frame, carry_at, 13, 1'b0);
                carry = 1'b0;
            end
            frames = $urandom_range(8, 16);
            repeat (frames)
            begin
                rx_calm = ($urandom_range(0, 4) == 0);
                kind    = $urandom_range(0, 9);
                fs      = need_start ? 1'b1 : 1'($urandom_range(0, 1));
                if (kind <= 6)
                begin
                    hdr_pick = ($urandom_range(0, 4) == 0) ? 8'($urandom) : hdr;
                    f = make_frame(hdr_pick, random_body(), $urandom_range(0, 5) == 0);
                    send_span(f, 0, 13, fs);
                    need_start = 1'b0;
                end
                else if (kind <= 8)
                begin
                    f = make_frame(hdr, random_body(), 1'b0);
                    send_span(f, 0, $urandom_range(0, 12), fs);
                    need_start = 1'b1;
                end
                else
                begin
                    n = $urandom_range(1, 20);
                    repeat (n) send_byte(8'($urandom), 1'($urandom_range(0, 7) == 0));
                    need_start = 1'b1;
                end
            end
            next_hdr = (phase == 0) ? 8'hFF : 8'($urandom);
            if ($urandom_range(0, 1) == 1)
            begin
                carry_frame = make_frame(next_hdr, random_body(), 1'b0);
                carry_at    = $urandom_range(1, 13);
                send_span(carry_frame, 0, carry_at - 1, need_start);
                carry      = 1'b1;
                need_start = 1'b0;
            end
            rx_pause();
            hdr = next_hdr;
            phase++;
        end

        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ frame_decoder_crc32_check_unit.f @@
rtl/fdc_pkg.sv
rtl/fdc_channels.sv
rtl/fdc_in_stage.sv
rtl/fdc_frame_core.sv
rtl/frame_decoder_crc32_check_unit.sv
bench/fdc_bench_pkg.sv
bench/fdc_result_checker.sv
bench/tb.sv
